// ===== rtl/fta_pkg.sv =====
// shared types and constants for the flow traffic aggregator
package fta_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W    = 64;
  localparam int KIND_W    = 8;
  localparam int PROTO_W   = 16;
  localparam int AMOUNT_W  = 32;
  localparam int TOTAL_W   = 40;
  localparam int REPORTS_W = 8;
  localparam int IVL_W     = 8;

  localparam logic [IVL_W-1:0] INTERVAL_RESET = 8'd100;

  typedef struct packed {
    logic [ADDR_W-1:0]   source_address;
    logic [ADDR_W-1:0]   dest_address;
    logic [KIND_W-1:0]   source_kind;
    logic [KIND_W-1:0]   dest_kind;
    logic [PROTO_W-1:0]  protocol_code;
    logic [AMOUNT_W-1:0] payload_bytes;
    logic [AMOUNT_W-1:0] encap_bytes;
  } report_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    source_address;
    logic [ADDR_W-1:0]    dest_address;
    logic [KIND_W-1:0]    source_kind;
    logic [KIND_W-1:0]    dest_kind;
    logic [PROTO_W-1:0]   protocol;
    logic [REPORTS_W-1:0] reports;
    logic [TOTAL_W-1:0]   bytes;
    logic [TOTAL_W-1:0]   encap;
  } entry_t;

endpackage

// ===== rtl/fta_front.sv =====
// front end: accepts reports and holds them in a short queue for the engine
module fta_front import fta_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  report_t in_item,
  output logic    q_valid,
  output report_t q_item,
  input  logic    q_pop
);

  report_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= QCNT_W'(count + 1'b1);
        2'b01:   count <= QCNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/fta_engine.sv =====
// back end: flow table search, update, insert and flush sequencer
module fta_engine import fta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IVL_W-1:0] interval,
  input  logic             q_valid,
  input  report_t          q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output entry_t           out_entry,
  output logic             out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_INSERT,
    ST_FL_READ,
    ST_FL_LOAD
  } state_t;

  state_t             state;
  report_t            cur;
  entry_t             upd;
  logic [IDX_W-1:0]   upd_idx;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_valid;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   flush_cnt;
  logic [IVL_W-1:0]   reports_since;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;

  logic               key_hit;
  logic               chk_last;
  logic               room;
  logic [CNT_W-1:0]   fill_after;
  logic [IVL_W-1:0]   reports_next;
  logic [IVL_W-1:0]   interval_eff;
  logic               flush_now;
  logic               out_free;
  logic               last_entry;

  function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] acc,
                                                 input logic [AMOUNT_W-1:0] amt);
    logic [TOTAL_W:0] s;
    s = {1'b0, acc} + (TOTAL_W + 1)'(amt);
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  // entry memory, read data refreshed every cycle from idx
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[idx];
  end

  assign key_hit = (rd_data.dest_address == cur.dest_address) &&
                   (rd_data.source_address == cur.source_address) &&
                   (rd_data.protocol == cur.protocol_code);
  assign chk_last     = (CNT_W'(chk_idx) == CNT_W'(fill - 1'b1));
  assign room         = (fill < CNT_W'(TABLE_DEPTH));
  assign reports_next = (reports_since == '1) ? reports_since
                                              : IVL_W'(reports_since + 1'b1);
  assign interval_eff = (interval == '0) ? IVL_W'(1) : interval;
  assign flush_now    = (reports_next >= interval_eff);
  assign out_free     = !out_valid || !out_stall;
  assign last_entry   = (CNT_W'(idx) == CNT_W'(flush_cnt - 1'b1));
  assign q_pop        = (state == ST_IDLE) && q_valid;

  always_comb begin
    fill_after = fill;
    mem_we     = 1'b0;
    mem_wa     = fill[IDX_W-1:0];
    mem_wd     = upd;
    case (state)
      ST_UPDATE: begin
        mem_we         = 1'b1;
        mem_wa         = upd_idx;
        mem_wd.reports = (upd.reports == '1) ? upd.reports
                                             : REPORTS_W'(upd.reports + 1'b1);
        mem_wd.bytes   = add_sat(upd.bytes, cur.payload_bytes);
        mem_wd.encap   = add_sat(upd.encap, cur.encap_bytes);
      end
      ST_INSERT: begin
        // a miss on a full table is dropped but still counted
        mem_we                = room;
        mem_wd.source_address = cur.source_address;
        mem_wd.dest_address   = cur.dest_address;
        mem_wd.source_kind    = cur.source_kind;
        mem_wd.dest_kind      = cur.dest_kind;
        mem_wd.protocol       = cur.protocol_code;
        mem_wd.reports        = REPORTS_W'(1);
        mem_wd.bytes          = TOTAL_W'(cur.payload_bytes);
        mem_wd.encap          = TOTAL_W'(cur.encap_bytes);
        if (room) begin
          fill_after = CNT_W'(fill + 1'b1);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill          <= '0;
      reports_since <= '0;
      chk_valid     <= 1'b0;
      out_valid     <= 1'b0;
      idx           <= '0;
    end else begin
      // the load state refills the output register itself
      if (out_valid && !out_stall && state != ST_FL_LOAD) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur       <= q_item;
            idx       <= '0;
            chk_valid <= 1'b0;
            state     <= (fill == '0) ? ST_INSERT : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // one entry issued and one compared per cycle
          idx       <= IDX_W'(idx + 1'b1);
          chk_idx   <= idx;
          chk_valid <= 1'b1;
          if (chk_valid) begin
            if (key_hit) begin
              upd     <= rd_data;
              upd_idx <= chk_idx;
              state   <= ST_UPDATE;
            end else if (chk_last) begin
              state <= ST_INSERT;
            end
          end
        end
        ST_UPDATE, ST_INSERT: begin
          if (flush_now) begin
            reports_since <= '0;
            fill          <= '0;
            flush_cnt     <= fill_after;
            idx           <= '0;
            state         <= (fill_after == '0) ? ST_IDLE : ST_FL_READ;
          end else begin
            reports_since <= reports_next;
            fill          <= fill_after;
            state         <= ST_IDLE;
          end
        end
        ST_FL_READ: begin
          state <= ST_FL_LOAD;
        end
        ST_FL_LOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_entry <= rd_data;
            out_last  <= last_entry;
            if (last_entry) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              idx   <= IDX_W'(idx + 1'b1);
              state <= ST_FL_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TABLE_DEPTH))
    else $error("flow table fill beyond depth");

  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FL_READ || state == ST_FL_LOAD) |-> !mem_we)
    else $error("table write during flush");

  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FL_LOAD && out_free && last_entry) |=>
      (state == ST_IDLE && fill == '0 && out_valid && out_last))
    else $error("flush did not end cleanly");

  a_pop_starts_work: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_SEARCH || state == ST_INSERT))
    else $error("popped report not taken up");
`endif

endmodule

// ===== rtl/flow_traffic_aggregator.sv =====
// top level of the flow traffic aggregator
// A report passes through the engine as follows: the key search streams one table entry per
// cycle through the entry memory's single read port, stopping at the first matching entry
// (an empty table skips it), then the update or insert state writes the updated or new entry.
// A two-transaction queue in front lets reports arrive while the engine searches. When the
// flush interval is reached, each stored flow is emitted in insertion order (read, then load
// of the output register), and no new report is taken until the flush is done. No clearing
// pass follows reset: the table is tracked by its fill count. The flush interval register
// must be written by the user only while the block is idle; the block itself does not
// enforce this, and cfg_ready is always high.
module flow_traffic_aggregator import fta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IVL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADDR_W-1:0]    source_address,
  input  logic [ADDR_W-1:0]    dest_address,
  input  logic [KIND_W-1:0]    source_kind,
  input  logic [KIND_W-1:0]    dest_kind,
  input  logic [PROTO_W-1:0]   protocol_code,
  input  logic [AMOUNT_W-1:0]  payload_bytes,
  input  logic [AMOUNT_W-1:0]  encap_bytes,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    out_source_address,
  output logic [ADDR_W-1:0]    out_dest_address,
  output logic [KIND_W-1:0]    out_source_kind,
  output logic [KIND_W-1:0]    out_dest_kind,
  output logic [PROTO_W-1:0]   out_protocol,
  output logic [REPORTS_W-1:0] report_total,
  output logic [TOTAL_W-1:0]   byte_total,
  output logic [TOTAL_W-1:0]   encap_total,
  output logic                 last_of_flush
);

  logic [IVL_W-1:0] interval;
  report_t          in_item;
  report_t          q_item;
  logic             q_valid;
  logic             q_pop;
  entry_t           out_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      interval <= cfg_data;
    end
  end

  assign in_item.source_address = source_address;
  assign in_item.dest_address   = dest_address;
  assign in_item.source_kind    = source_kind;
  assign in_item.dest_kind      = dest_kind;
  assign in_item.protocol_code  = protocol_code;
  assign in_item.payload_bytes  = payload_bytes;
  assign in_item.encap_bytes    = encap_bytes;

  fta_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  fta_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .interval  (interval),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_entry (out_entry),
    .out_last  (last_of_flush)
  );

  assign out_source_address = out_entry.source_address;
  assign out_dest_address   = out_entry.dest_address;
  assign out_source_kind    = out_entry.source_kind;
  assign out_dest_kind      = out_entry.dest_kind;
  assign out_protocol       = out_entry.protocol;
  assign report_total       = out_entry.reports;
  assign byte_total         = out_entry.bytes;
  assign encap_total        = out_entry.encap;

endmodule

// ===== dv/flow_table_checker.sv =====
`timescale 1ns / 100ps
// flow table checker: mirrors the aggregator's flow table and compares every flushed flow
module flow_table_checker import fta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [IVL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [ADDR_W-1:0]    source_address,
  input  logic [ADDR_W-1:0]    dest_address,
  input  logic [KIND_W-1:0]    source_kind,
  input  logic [KIND_W-1:0]    dest_kind,
  input  logic [PROTO_W-1:0]   protocol_code,
  input  logic [AMOUNT_W-1:0]  payload_bytes,
  input  logic [AMOUNT_W-1:0]  encap_bytes,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ADDR_W-1:0]    out_source_address,
  input  logic [ADDR_W-1:0]    out_dest_address,
  input  logic [KIND_W-1:0]    out_source_kind,
  input  logic [KIND_W-1:0]    out_dest_kind,
  input  logic [PROTO_W-1:0]   out_protocol,
  input  logic [REPORTS_W-1:0] report_total,
  input  logic [TOTAL_W-1:0]   byte_total,
  input  logic [TOTAL_W-1:0]   encap_total,
  input  logic                 last_of_flush,
  output int                   fail_count,
  output int                   pending
);

  localparam int unsigned SINCE_FLUSH_MAX = 255;

  typedef struct packed {
    entry_t flow;
    logic   last;
  } flushed_t;

  entry_t           flows [TABLE_DEPTH];
  flushed_t         due_flows [$];
  int unsigned      held_flows;
  int unsigned      reports_seen;
  logic [IVL_W-1:0] flush_interval;
  report_t          seen_report;
  flushed_t         want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
                                                 input logic [AMOUNT_W-1:0] amount);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, acc} + (TOTAL_W + 1)'(amount);
    return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

  function automatic int field_miss(input string name, input logic [63:0] exp_val,
                                    input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  // merge one report into the table, queue the whole table when the interval is reached
  task automatic absorb_report(input report_t r);
    int unsigned slot;
    int unsigned threshold;
    flushed_t    f;
    slot = 0;
    while (slot < held_flows && !(flows[slot].dest_address == r.dest_address &&
                                  flows[slot].source_address == r.source_address &&
                                  flows[slot].protocol == r.protocol_code))
      slot++;
    if (slot < held_flows) begin
      if (flows[slot].reports != {REPORTS_W{1'b1}})
        flows[slot].reports = flows[slot].reports + 1'b1;
      flows[slot].bytes = sat_add(flows[slot].bytes, r.payload_bytes);
      flows[slot].encap = sat_add(flows[slot].encap, r.encap_bytes);
    end else if (held_flows < TABLE_DEPTH) begin
      flows[held_flows].source_address = r.source_address;
      flows[held_flows].dest_address   = r.dest_address;
      flows[held_flows].source_kind    = r.source_kind;
      flows[held_flows].dest_kind      = r.dest_kind;
      flows[held_flows].protocol       = r.protocol_code;
      flows[held_flows].reports        = REPORTS_W'(1);
      flows[held_flows].bytes          = TOTAL_W'(r.payload_bytes);
      flows[held_flows].encap          = TOTAL_W'(r.encap_bytes);
      held_flows++;
    end
    // a dropped report on a full table still counts toward the interval
    if (reports_seen < SINCE_FLUSH_MAX)
      reports_seen++;
    threshold = (flush_interval == 0) ? 1 : flush_interval;
    if (reports_seen >= threshold) begin
      for (int unsigned i = 0; i < held_flows; i++) begin
        f.flow = flows[i];
        f.last = (i + 1 == held_flows);
        due_flows.push_back(f);
      end
      held_flows   = 0;
      reports_seen = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_flows     = 0;
      reports_seen   = 0;
      flush_interval = INTERVAL_RESET;
      due_flows.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        flush_interval = cfg_data;
      if (out_valid && !out_stall) begin
        if (due_flows.size() == 0) begin
          $display("%0t: flow transaction with none expected, actual src %0h dst %0h", $time,
                   out_source_address, out_dest_address);
          fail_count++;
        end else begin
          want = due_flows.pop_front();
          fail_count += field_miss("out_source_address", want.flow.source_address,
                                   out_source_address);
          fail_count += field_miss("out_dest_address", want.flow.dest_address,
                                   out_dest_address);
          fail_count += field_miss("out_source_kind", 64'(want.flow.source_kind),
                                   64'(out_source_kind));
          fail_count += field_miss("out_dest_kind", 64'(want.flow.dest_kind),
                                   64'(out_dest_kind));
          fail_count += field_miss("out_protocol", 64'(want.flow.protocol), 64'(out_protocol));
          fail_count += field_miss("report_total", 64'(want.flow.reports), 64'(report_total));
          fail_count += field_miss("byte_total", 64'(want.flow.bytes), 64'(byte_total));
          fail_count += field_miss("encap_total", 64'(want.flow.encap), 64'(encap_total));
          fail_count += field_miss("last_of_flush", 64'(want.last), 64'(last_of_flush));
        end
      end
      if (in_valid && !in_stall) begin
        seen_report.source_address = source_address;
        seen_report.dest_address   = dest_address;
        seen_report.source_kind    = source_kind;
        seen_report.dest_kind      = dest_kind;
        seen_report.protocol_code  = protocol_code;
        seen_report.payload_bytes  = payload_bytes;
        seen_report.encap_bytes    = encap_bytes;
        absorb_report(seen_report);
      end
    end
    pending = due_flows.size();
  end

endmodule

// ===== dv/tb_flow_traffic_aggregator.sv =====
`timescale 1ns / 100ps
// testbench top for the flow traffic aggregator: reset, report stimulus and verdict
module tb_flow_traffic_aggregator;
  import fta_pkg::*;

  // two queued reports behind a full-table search, plus a margin
  localparam int DRAIN_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IVL_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_W-1:0]    source_address = '0;
  logic [ADDR_W-1:0]    dest_address = '0;
  logic [KIND_W-1:0]    source_kind = '0;
  logic [KIND_W-1:0]    dest_kind = '0;
  logic [PROTO_W-1:0]   protocol_code = '0;
  logic [AMOUNT_W-1:0]  payload_bytes = '0;
  logic [AMOUNT_W-1:0]  encap_bytes = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    out_source_address;
  logic [ADDR_W-1:0]    out_dest_address;
  logic [KIND_W-1:0]    out_source_kind;
  logic [KIND_W-1:0]    out_dest_kind;
  logic [PROTO_W-1:0]   out_protocol;
  logic [REPORTS_W-1:0] report_total;
  logic [TOTAL_W-1:0]   byte_total;
  logic [TOTAL_W-1:0]   encap_total;
  logic                 last_of_flush;
  int                   fail_count;
  int                   pending;

  int      idle_pct = 0;
  int      stall_pct = 0;
  report_t known_flows [$];
  report_t probe;

  flow_traffic_aggregator DUT (.*);
  flow_table_checker flow_check (.*);

  always #1 clk = ~clk;

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  function automatic report_t key_report(input logic [ADDR_W-1:0] src,
                                         input logic [ADDR_W-1:0] dst,
                                         input logic [PROTO_W-1:0] proto,
                                         input logic [KIND_W-1:0] skind,
                                         input logic [KIND_W-1:0] dkind,
                                         input logic [AMOUNT_W-1:0] pay,
                                         input logic [AMOUNT_W-1:0] enc);
    report_t r;
    r.source_address = src;
    r.dest_address   = dst;
    r.protocol_code  = proto;
    r.source_kind    = skind;
    r.dest_kind      = dkind;
    r.payload_bytes  = pay;
    r.encap_bytes    = enc;
    return r;
  endfunction

  function automatic logic [AMOUNT_W-1:0] random_amount();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25)
      return {AMOUNT_W{1'b1}};
    if (roll < 35)
      return '0;
    return $urandom;
  endfunction

  // new flows are either fresh keys or near misses of a known key in one key field
  function automatic report_t pick_report(input int fresh_pct);
    report_t r;
    if (known_flows.size() == 0 || $urandom_range(99) < fresh_pct) begin
      if (known_flows.size() != 0 && $urandom_range(2) == 0) begin
        r = known_flows[$urandom_range(known_flows.size() - 1)];
        case ($urandom_range(2))
          0: r.source_address[$urandom_range(ADDR_W - 1)] ^= 1'b1;
          1: r.dest_address[$urandom_range(ADDR_W - 1)] ^= 1'b1;
          default: r.protocol_code[$urandom_range(PROTO_W - 1)] ^= 1'b1;
        endcase
      end else begin
        r.source_address = {$urandom, $urandom};
        r.dest_address   = {$urandom, $urandom};
        r.protocol_code  = PROTO_W'($urandom_range(16'hffff));
      end
      known_flows.push_back(r);
    end else begin
      r = known_flows[$urandom_range(known_flows.size() - 1)];
    end
    r.source_kind   = KIND_W'($urandom_range(255));
    r.dest_kind     = KIND_W'($urandom_range(255));
    r.payload_bytes = random_amount();
    r.encap_bytes   = random_amount();
    return r;
  endfunction

  // entered and left at a falling edge; valid stays up for a back-to-back transaction
  task automatic send_report(input report_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    source_address <= r.source_address;
    dest_address   <= r.dest_address;
    source_kind    <= r.source_kind;
    dest_kind      <= r.dest_kind;
    protocol_code  <= r.protocol_code;
    payload_bytes  <= r.payload_bytes;
    encap_bytes    <= r.encap_bytes;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every queued flow, then give the engine time to finish a silent report
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [IVL_W-1:0] interval, input int reports,
                           input int sender_idle, input int receiver_stall,
                           input int fresh_pct);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    write_interval(interval);
    repeat (reports) send_report(pick_report(fresh_pct));
    settle();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_pct  = 17;
    stall_pct = 17;

    // zero interval flushes after every report; all-zero and all-one fields
    write_interval(8'd0);
    send_report(key_report('0, '0, '0, '0, '0, '0, '0));
    send_report(key_report('1, '1, '1, '1, '1, '1, '1));
    settle();

    // a hit with new kinds and carry past 32 bits, then keys that differ in one field only
    write_interval(8'd5);
    probe = key_report(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 16'h0800,
                       8'h01, 8'h02, 32'hffff_ffff, 32'h0000_0001);
    send_report(probe);
    send_report(key_report(probe.source_address, probe.dest_address, probe.protocol_code,
                           8'haa, 8'h55, 32'hffff_ffff, 32'hffff_ffff));
    send_report(key_report(probe.source_address, probe.dest_address, 16'h0801,
                           8'h80, 8'h7f, 32'h0000_0010, '0));
    send_report(key_report(probe.source_address ^ 64'h1, probe.dest_address,
                           probe.protocol_code, 8'hff, 8'h00, '0, 32'h8000_0000));
    send_report(key_report(probe.source_address, probe.dest_address ^ 64'h8000_0000_0000_0000,
                           probe.protocol_code, 8'h00, 8'hff, 32'h1234_5678, 32'h9abc_def0));
    settle();

    // one flow merging several maximum reports
    write_interval(8'd3);
    repeat (3)
      send_report(key_report(64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff, 16'hffff,
                             8'h11, 8'h22, 32'hffff_ffff, 32'hffff_ffff));
    settle();

    // interval lowered below the reports already counted: the next report flushes
    write_interval(8'd255);
    send_report(probe);
    send_report(key_report(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 16'h5555,
                           8'h5a, 8'ha5, 32'h5555_5555, 32'haaaa_aaaa));
    send_report(key_report(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 16'haaaa,
                           8'ha5, 8'h5a, 32'haaaa_aaaa, 32'h5555_5555));
    settle();
    write_interval(8'd2);
    send_report(probe);
    settle();

    // mostly new flows against a long interval fill the table and drop the rest
    run_phase(8'd100, 100, 0, 0, 75);
    run_phase(8'd7, 50, 76, 0, 40);
    run_phase(8'd1, 30, 0, 76, 50);
    run_phase(8'd255, 40, 17, 17, 50);
    run_phase(8'd13, 40, 17, 17, 30);

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
